// ----- rtl/ascon_pkg.sv -----
// shared types, codes and constants for the ascon aead128 engine
// no dependencies; imported by ascon_round and ascon_aead128_engine
package ascon_pkg;

	typedef logic [4:0][63:0] lanes_t;

	localparam logic [63:0] ASCON_IV      = 64'h00001000808c0001;
	localparam logic [63:0] ASCON_SEP_BIT = 64'h8000000000000000;
	localparam logic [7:0]  ASCON_PAD     = 8'h01;
	localparam logic [4:0]  ASCON_BLOCK   = 5'd16;
	localparam logic [3:0]  ROUND_LAST    = 4'd11;
	localparam logic [3:0]  ROUND_FIRST12 = 4'd0;
	localparam logic [3:0]  ROUND_FIRST8  = 4'd4;

	localparam int TDATA_W  = 136;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		OP_START  = 2'd0,
		OP_AD     = 2'd1,
		OP_DATA   = 2'd2,
		OP_FINISH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_AUTH = 2'd1,
		ST_SEQ  = 2'd2
	} status_t;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_START  = 2'd1;
	localparam logic [1:0] PH_OPEN   = 2'd2;
	localparam logic [1:0] PH_CLOSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECRYPT  = 2'd2;

	function automatic logic [63:0] rotr(input logic [63:0] v, input int unsigned n);
		return (v >> n) | (v << (64 - n));
	endfunction

	// constant of round r: high nibble counts down, low nibble counts up
	function automatic logic [7:0] round_const(input logic [3:0] r);
		return {4'(4'd15 - r), r};
	endfunction

endpackage

// ----- rtl/ascon_round.sv -----
// one round of the ascon permutation: constant add, s-box layer, linear layer
// depends on ascon_pkg
module ascon_round (
	input  ascon_pkg::lanes_t   lanes_in,
	input  logic [3:0]          round_idx,
	output ascon_pkg::lanes_t   lanes_out
);
	import ascon_pkg::*;

	logic [63:0] x0, x1, x2, x3, x4;
	logic [63:0] t0, t1, t2, t3, t4;

	always_comb begin
		x0 = lanes_in[0];
		x1 = lanes_in[1];
		x2 = lanes_in[2] ^ {56'd0, round_const(round_idx)};
		x3 = lanes_in[3];
		x4 = lanes_in[4];
		// bit-sliced s-box
		x0 = x0 ^ x4;
		x4 = x4 ^ x3;
		x2 = x2 ^ x1;
		t0 = ~x0 & x1;
		t1 = ~x1 & x2;
		t2 = ~x2 & x3;
		t3 = ~x3 & x4;
		t4 = ~x4 & x0;
		x0 = x0 ^ t1;
		x1 = x1 ^ t2;
		x2 = x2 ^ t3;
		x3 = x3 ^ t4;
		x4 = x4 ^ t0;
		x1 = x1 ^ x0;
		x0 = x0 ^ x4;
		x3 = x3 ^ x2;
		x2 = ~x2;
		lanes_out[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
		lanes_out[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
		lanes_out[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
		lanes_out[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
		lanes_out[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
	end

endmodule

// ----- rtl/ascon_aead128_engine.sv -----
// Ascon-AEAD128 engine (NIST SP 800-232) with a single shared round unit.
// Each input word is one item: start with nonce, associated data block, payload block or
// finish, selected by s_tuser; every item yields exactly one result word. One permutation
// round runs per clock through the single round unit. A start or finish item runs 12
// rounds, a key add and the output load; an associated data block or a full 16-byte
// payload block runs the rounds from ROUND_FIRST8 and the output load; a partial payload
// block or an out-of-sequence item goes straight to the output load, which waits for a
// free output register. The next item is taken in the cycle after the load. s_tready is
// high only while the engine has no item in flight; a result waits in the output register,
// so the next item is taken while the previous result is not yet read. The user writes key
// and decrypt mode via the cfg channel only between items; the engine does not check it.
// depends on ascon_pkg and ascon_round
module ascon_aead128_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ascon_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// data_low [63:0], data_high [127:64], valid_bytes [132:128], zero [135:133]
	input  logic [ascon_pkg::TDATA_W-1:0] s_tdata,
	// op [1:0]
	input  logic [1:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// out_low [63:0], out_high [127:64], out_bytes [132:128], zero [135:133]
	output logic [ascon_pkg::TDATA_W-1:0] m_tdata,
	// status [1:0]
	output logic [1:0]                    m_tuser
);
	import ascon_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PERM,
		S_POST,
		S_HOLD
	} state_t;

	state_t      state_q;
	lanes_t      lanes_q;
	lanes_t      round_out;
	logic [3:0]  rnd_q;
	logic [63:0] key_lo_q, key_hi_q;
	logic        dec_q;
	logic        dec_item_q;
	logic        fin_q;
	logic        post_q;
	logic [1:0]  phase_q;
	logic        sep_q;
	logic [63:0] res_lo_q, res_hi_q;
	logic [4:0]  res_bytes_q;
	status_t     res_status_q;
	logic [63:0] tag_in_lo_q, tag_in_hi_q;

	// item decode and absorb
	op_t         op;
	logic [63:0] din_lo, din_hi;
	logic [4:0]  nb;
	logic [63:0] mlo, mhi, plo, phi;
	logic        ok_ad, ok_pl, ok_fin;
	lanes_t      acc_lanes;
	logic [63:0] acc_lo, acc_hi;
	logic [4:0]  acc_bytes;
	status_t     acc_status;
	logic        acc_perm;
	logic [3:0]  acc_rnd;
	logic        acc_post;
	logic [1:0]  acc_phase;
	logic        acc_sep;
	logic        accept;
	logic        load_out;
	logic [63:0] post_x3, post_x4;
	logic [63:0] diff;

	ascon_round u_round (
		.lanes_in  (lanes_q),
		.round_idx (rnd_q),
		.lanes_out (round_out)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign load_out  = (state_q == S_HOLD) && (!m_tvalid || m_tready);

	assign op     = op_t'(s_tuser);
	assign din_lo = s_tdata[63:0];
	assign din_hi = s_tdata[127:64];
	assign nb     = (s_tdata[132:128] > ASCON_BLOCK) ? ASCON_BLOCK : s_tdata[132:128];

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			mlo[8*i +: 8] = (5'(i) < nb) ? 8'hff : 8'h00;
			mhi[8*i +: 8] = (5'(i + 8) < nb) ? 8'hff : 8'h00;
			plo[8*i +: 8] = (5'(i) == nb) ? ASCON_PAD : 8'h00;
			phi[8*i +: 8] = (5'(i + 8) == nb) ? ASCON_PAD : 8'h00;
		end
	end

	assign ok_ad  = !sep_q && (phase_q == PH_START || phase_q == PH_OPEN);
	assign ok_pl  = (!sep_q && (phase_q == PH_START || phase_q == PH_CLOSED)) ||
	                (sep_q && phase_q == PH_START);
	assign ok_fin = sep_q && (phase_q == PH_CLOSED);

	always_comb begin
		acc_lanes  = lanes_q;
		acc_lo     = '0;
		acc_hi     = '0;
		acc_bytes  = '0;
		acc_status = ST_OK;
		acc_perm   = 1'b0;
		acc_rnd    = ROUND_FIRST12;
		acc_post   = 1'b0;
		acc_phase  = phase_q;
		acc_sep    = sep_q;
		unique case (op)
			OP_START: begin
				acc_lanes = {din_hi, din_lo, key_hi_q, key_lo_q, ASCON_IV};
				acc_perm  = 1'b1;
				acc_post  = 1'b1;
				acc_phase = PH_START;
				acc_sep   = 1'b0;
			end
			OP_AD: begin
				if (ok_ad) begin
					acc_lanes[0] = lanes_q[0] ^ (din_lo & mlo) ^ plo;
					acc_lanes[1] = lanes_q[1] ^ (din_hi & mhi) ^ phi;
					acc_perm     = 1'b1;
					acc_rnd      = ROUND_FIRST8;
					acc_phase    = (nb == ASCON_BLOCK) ? PH_OPEN : PH_CLOSED;
				end else begin
					acc_status = ST_SEQ;
				end
			end
			OP_DATA: begin
				if (ok_pl) begin
					// domain separation before the first payload block
					if (!sep_q) begin
						acc_lanes[4] = lanes_q[4] ^ ASCON_SEP_BIT;
					end
					acc_sep = 1'b1;
					if (dec_q) begin
						acc_lo       = (lanes_q[0] ^ din_lo) & mlo;
						acc_hi       = (lanes_q[1] ^ din_hi) & mhi;
						acc_lanes[0] = ((lanes_q[0] & ~mlo) | (din_lo & mlo)) ^ plo;
						acc_lanes[1] = ((lanes_q[1] & ~mhi) | (din_hi & mhi)) ^ phi;
					end else begin
						acc_lanes[0] = lanes_q[0] ^ (din_lo & mlo) ^ plo;
						acc_lanes[1] = lanes_q[1] ^ (din_hi & mhi) ^ phi;
						acc_lo       = acc_lanes[0] & mlo;
						acc_hi       = acc_lanes[1] & mhi;
					end
					acc_bytes = nb;
					acc_rnd   = ROUND_FIRST8;
					if (nb == ASCON_BLOCK) begin
						acc_perm  = 1'b1;
						acc_phase = PH_START;
					end else begin
						acc_phase = PH_CLOSED;
					end
				end else begin
					acc_status = ST_SEQ;
				end
			end
			OP_FINISH: begin
				if (ok_fin) begin
					acc_lanes[2] = lanes_q[2] ^ key_lo_q;
					acc_lanes[3] = lanes_q[3] ^ key_hi_q;
					acc_perm     = 1'b1;
					acc_post     = 1'b1;
					acc_phase    = PH_IDLE;
					acc_sep      = 1'b0;
				end else begin
					acc_status = ST_SEQ;
				end
			end
			default: begin
				acc_status = ST_SEQ;
			end
		endcase
	end

	assign post_x3 = lanes_q[3] ^ key_lo_q;
	assign post_x4 = lanes_q[4] ^ key_hi_q;
	// full xor/or reduction, no early exit
	assign diff    = (post_x3 ^ tag_in_lo_q) | (post_x4 ^ tag_in_hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
			dec_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY_LOW:  key_lo_q <= cfg_data;
				REG_KEY_HIGH: key_hi_q <= cfg_data;
				REG_DECRYPT:  dec_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lanes_q      <= '0;
			rnd_q        <= '0;
			phase_q      <= PH_IDLE;
			sep_q        <= 1'b0;
			fin_q        <= 1'b0;
			post_q       <= 1'b0;
			dec_item_q   <= 1'b0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= ST_OK;
			res_lo_q     <= '0;
			res_hi_q     <= '0;
			res_bytes_q  <= '0;
			res_status_q <= ST_OK;
			tag_in_lo_q  <= '0;
			tag_in_hi_q  <= '0;
		end else begin
			if (load_out) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {3'd0, res_bytes_q, res_hi_q, res_lo_q};
				m_tuser  <= res_status_q;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						lanes_q      <= acc_lanes;
						rnd_q        <= acc_rnd;
						phase_q      <= acc_phase;
						sep_q        <= acc_sep;
						fin_q        <= (op == OP_FINISH);
						post_q       <= acc_post;
						dec_item_q   <= dec_q;
						res_lo_q     <= acc_lo;
						res_hi_q     <= acc_hi;
						res_bytes_q  <= acc_bytes;
						res_status_q <= acc_status;
						tag_in_lo_q  <= din_lo;
						tag_in_hi_q  <= din_hi;
						if (acc_perm) begin
							state_q <= S_PERM;
						end else begin
							state_q <= S_HOLD;
						end
					end
				end
				S_PERM: begin
					lanes_q <= round_out;
					rnd_q   <= rnd_q + 4'd1;
					if (rnd_q == ROUND_LAST) begin
						// only start and finish carry a key add after the rounds
						state_q <= post_q ? S_POST : S_HOLD;
					end
				end
				S_POST: begin
					lanes_q[3] <= post_x3;
					lanes_q[4] <= post_x4;
					if (fin_q) begin
						if (dec_item_q) begin
							res_status_q <= (diff == '0) ? ST_OK : ST_AUTH;
						end else begin
							res_lo_q    <= post_x3;
							res_hi_q    <= post_x4;
							res_bytes_q <= ASCON_BLOCK;
						end
					end
					state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	property p_item_takes_time;
		@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready;
	endproperty
	a_item_takes_time: assert property (p_item_takes_time)
		else $error("engine took two items in consecutive cycles");

	property p_round_range;
		@(posedge clk) disable iff (!arst_n)
		(state_q == S_PERM) |-> (rnd_q <= ROUND_LAST);
	endproperty
	a_round_range: assert property (p_round_range)
		else $error("round counter ran past the last round");

	property p_auth_no_data;
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0);
	endproperty
	a_auth_no_data: assert property (p_auth_no_data)
		else $error("error status returned with nonzero data");

	property p_bytes_range;
		@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[132:128] <= ASCON_BLOCK);
	endproperty
	a_bytes_range: assert property (p_bytes_range)
		else $error("result byte count above one block");

	property p_sep_phase;
		@(posedge clk) disable iff (!arst_n)
		sep_q |-> (phase_q == PH_START || phase_q == PH_CLOSED);
	endproperty
	a_sep_phase: assert property (p_sep_phase)
		else $error("separated session in an impossible phase");

endmodule
